### rtl/dda_line_rasterizer_assert.svh
// Assertion macros for the line rasterizer. They expect clk and rst in scope.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

  localparam int FIELD_W = 6;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t start_x;
    field_t start_y;
    field_t end_x;
    field_t end_y;
  } dda_in_t;

  typedef struct packed {
    field_t pixel_x;
    field_t pixel_y;
    logic   last_point;
  } dda_out_t;

  // microprogram addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE      = 3'd0;
  localparam step_t STEP_SETUP     = 3'd1;
  localparam step_t STEP_DIV_FIRST = 3'd2;
  localparam step_t STEP_DIV       = 3'd3;
  localparam step_t STEP_INC       = 3'd4;
  localparam step_t STEP_EMIT      = 3'd5;
  localparam step_t STEP_DONE      = 3'd6;

  typedef enum logic [1:0] {
    GATE_NONE,
    GATE_IN,
    GATE_OUT
  } gate_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_DIV_FIRST,
    OP_DIV_STEP,
    OP_INC,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_STEPS_ZERO,
    COND_CNT_NZ,
    COND_NOT_LAST
  } cond_t;

  // one microinstruction: taken jump goes to target, otherwise fall through
  typedef struct packed {
    gate_t gate;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_go;
    logic out_free;
    logic steps_zero;
    logic cnt_nz;
    logic not_last;
  } status_t;

endpackage

`default_nettype wire

### rtl/dda_seq.sv
`default_nettype none

module dda_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dda_pkg::status_t status,
  output dda_pkg::ctrl_t        ctrl,
  output logic                  fire
);

  dda_pkg::step_t pc;
  dda_pkg::step_t pc_next;
  logic           taken;

  function automatic dda_pkg::ctrl_t rom_word(input dda_pkg::step_t addr);
    dda_pkg::ctrl_t w;
    w = '{dda_pkg::GATE_NONE, dda_pkg::OP_NONE, dda_pkg::COND_ALWAYS, dda_pkg::STEP_IDLE};
    case (addr)
      dda_pkg::STEP_IDLE: begin
        w = '{dda_pkg::GATE_IN, dda_pkg::OP_LOAD, dda_pkg::COND_NEVER, dda_pkg::STEP_IDLE};
      end
      dda_pkg::STEP_SETUP: begin
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_SETUP, dda_pkg::COND_NEVER,
              dda_pkg::STEP_IDLE};
      end
      dda_pkg::STEP_DIV_FIRST: begin
        // a point segment has nothing to divide
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_DIV_FIRST, dda_pkg::COND_STEPS_ZERO,
              dda_pkg::STEP_INC};
      end
      dda_pkg::STEP_DIV: begin
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_DIV_STEP, dda_pkg::COND_CNT_NZ,
              dda_pkg::STEP_DIV};
      end
      dda_pkg::STEP_INC: begin
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_INC, dda_pkg::COND_NEVER, dda_pkg::STEP_IDLE};
      end
      dda_pkg::STEP_EMIT: begin
        w = '{dda_pkg::GATE_OUT, dda_pkg::OP_EMIT, dda_pkg::COND_NOT_LAST,
              dda_pkg::STEP_EMIT};
      end
      dda_pkg::STEP_DONE: begin
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_NONE, dda_pkg::COND_ALWAYS,
              dda_pkg::STEP_IDLE};
      end
      default: begin
        w = '{dda_pkg::GATE_NONE, dda_pkg::OP_NONE, dda_pkg::COND_ALWAYS,
              dda_pkg::STEP_IDLE};
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom_word(pc);

  always_comb begin
    case (ctrl.gate)
      dda_pkg::GATE_NONE: fire = 1'b1;
      dda_pkg::GATE_IN:   fire = status.in_go;
      dda_pkg::GATE_OUT:  fire = status.out_free;
      default:            fire = 1'b0;
    endcase

    case (ctrl.cond)
      dda_pkg::COND_NEVER:      taken = 1'b0;
      dda_pkg::COND_ALWAYS:     taken = 1'b1;
      dda_pkg::COND_STEPS_ZERO: taken = status.steps_zero;
      dda_pkg::COND_CNT_NZ:     taken = status.cnt_nz;
      dda_pkg::COND_NOT_LAST:   taken = status.not_last;
      default:                  taken = 1'b0;
    endcase

    if (!fire) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + dda_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dda_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/dda_line_rasterizer.sv
// DDA line rasterizer: takes one segment item (two endpoints in a tile of
// 2^COORD_BITS pixels square, upper field bits ignored) and returns steps+1
// point items, steps = max(|dx|, |dy|), each rounded half up to the nearest
// pixel, the final one flagged by last_point and equal to the end point.
// A small microprogram sequences the work: the minor-axis increment comes
// from a restoring divider that yields one quotient bit per cycle
// (FRAC_BITS + 1 bits), then one point is emitted per cycle while the output
// is not stalled. in_ready is high only while the sequencer waits for a
// segment; the output register lets the last point wait for the consumer
// while the next segment is taken.
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dda_pkg::dda_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dda_pkg::dda_out_t      out_data
);

  `include "dda_line_rasterizer_assert.svh"

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS);

  localparam logic [ACC_W-1:0] ONE  = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  dda_pkg::ctrl_t   ctrl;
  dda_pkg::status_t status;
  logic             fire;

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] steps;
  logic [COORD_BITS-1:0] minor;
  logic                  x_major, neg_x, neg_y;
  logic [COORD_BITS-1:0] rem;
  logic [Q_W-1:0]        quo;
  logic [CNT_W-1:0]      cnt;
  logic [ACC_W-1:0]      x_inc, y_inc;
  logic [ACC_W-1:0]      x_acc, y_acc;
  logic [COORD_BITS-1:0] k;

  logic [COORD_BITS:0]   dx, dy, adx, ady;
  logic [COORD_BITS:0]   shifted, diff;
  logic                  ge;
  logic [ACC_W-1:0]      minor_inc, x_mag, y_mag;
  logic [ACC_W-1:0]      x_round, y_round;

  logic                  in_fire, emit_go, emit_end, emit_mid, at_end;

  dda_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .fire   (fire)
  );

  assign in_ready = (ctrl.gate == dda_pkg::GATE_IN);

  always_comb begin
    status.in_go      = in_valid;
    status.out_free   = !out_valid || out_ready;
    status.steps_zero = (steps == '0);
    status.cnt_nz     = (cnt != '0);
    status.not_last   = (k != '0);
  end

  // setup arithmetic on the latched endpoints
  always_comb begin
    dx  = {1'b0, ex} - {1'b0, sx};
    dy  = {1'b0, ey} - {1'b0, sy};
    adx = dx[COORD_BITS] ? ((COORD_BITS+1)'(0) - dx) : dx;
    ady = dy[COORD_BITS] ? ((COORD_BITS+1)'(0) - dy) : dy;
  end

  // one restoring division step
  always_comb begin
    shifted = {rem, 1'b0};
    ge      = (shifted >= {1'b0, steps});
    diff    = shifted - {1'b0, steps};
  end

  always_comb begin
    minor_inc = ACC_W'(quo);
    x_mag     = x_major ? ONE : minor_inc;
    y_mag     = x_major ? minor_inc : ONE;
    x_round   = x_acc + HALF;
    y_round   = y_acc + HALF;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctrl.op)
        dda_pkg::OP_LOAD: begin
          sx <= in_data.start_x[COORD_BITS-1:0];
          sy <= in_data.start_y[COORD_BITS-1:0];
          ex <= in_data.end_x[COORD_BITS-1:0];
          ey <= in_data.end_y[COORD_BITS-1:0];
        end
        dda_pkg::OP_SETUP: begin
          x_major <= (adx >= ady);
          steps   <= (adx >= ady) ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
          minor   <= (adx >= ady) ? ady[COORD_BITS-1:0] : adx[COORD_BITS-1:0];
          neg_x   <= dx[COORD_BITS];
          neg_y   <= dy[COORD_BITS];
        end
        dda_pkg::OP_DIV_FIRST: begin
          // integer quotient bit: the minor delta never exceeds steps
          quo <= Q_W'(minor >= steps);
          rem <= (minor >= steps) ? (minor - steps) : minor;
          cnt <= CNT_W'(FRAC_BITS - 1);
        end
        dda_pkg::OP_DIV_STEP: begin
          quo <= {quo[Q_W-2:0], ge};
          rem <= ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
          cnt <= cnt - CNT_W'(1);
        end
        dda_pkg::OP_INC: begin
          x_inc <= neg_x ? (ACC_W'(0) - x_mag) : x_mag;
          y_inc <= neg_y ? (ACC_W'(0) - y_mag) : y_mag;
          x_acc <= ACC_W'(sx) << FRAC_BITS;
          y_acc <= ACC_W'(sy) << FRAC_BITS;
          k     <= steps;
        end
        dda_pkg::OP_EMIT: begin
          out_data.pixel_x    <= dda_pkg::field_t'(x_round[FRAC_BITS +: COORD_BITS]);
          out_data.pixel_y    <= dda_pkg::field_t'(y_round[FRAC_BITS +: COORD_BITS]);
          out_data.last_point <= (k == '0);
          x_acc <= x_acc + x_inc;
          y_acc <= y_acc + y_inc;
          k     <= k - COORD_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctrl.op == dda_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign emit_go  = fire && (ctrl.op == dda_pkg::OP_EMIT);
  assign emit_end = emit_go && (k == '0);
  assign emit_mid = emit_go && (k != '0);
  assign at_end   = (out_data.pixel_x == dda_pkg::field_t'(ex)) &&
                    (out_data.pixel_y == dda_pkg::field_t'(ey));

  `DDA_ASSERT_NEXT(a_load_then_setup, in_fire, ctrl.op == dda_pkg::OP_SETUP, "setup missed")

  `DDA_ASSERT_NEXT(a_last_flag, emit_end, out_valid && out_data.last_point, "last not flagged")

  `DDA_ASSERT_NEXT(a_no_early_last, emit_mid, !out_data.last_point, "early last flag")

  `DDA_ASSERT_NEXT(a_end_point, emit_end, at_end, "final point not at end point")

  `DDA_ASSERT_SAME(a_ready_idle, in_ready, ctrl.op != dda_pkg::OP_EMIT, "taken mid-emit")

endmodule

`default_nettype wire
